// File: hdl/iba_pkg.sv
`default_nettype none

package iba_pkg;

  localparam int DEF_TOTAL_BLOCKS     = 128;
  localparam int DEF_FILE_BLOCK_LIMIT = 10;

  localparam int MAP_W   = 16;
  localparam int PICK_W  = 4;
  localparam int COUNT_W = 8;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int BLK_W   = 7;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    REQ_CREATE = 1'b0,
    REQ_READ   = 1'b1
  } req_t;

  function automatic logic [PICK_W-1:0] lowest_zero(input logic [MAP_W-1:0] word);
    logic [PICK_W-1:0] idx;
    idx = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = PICK_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hdl/iba_ram.sv
`default_nettype none

module iba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/indexed_block_allocator_top.sv
// Block allocator with a first-fit used/free bitmap and one file's index table.
// Input channel (in_valid/in_ready): one request, a create with a block count
// or a read of the stored index. in_ready is high only while no request is in
// progress. Result channel (out_valid/out_ready): one or more results per
// request, the final one marked by out_last.
// Create: counts above FILE_BLOCK_LIMIT or zero give one result from the
// S_EMIT_ONE state. Otherwise blocks are allocated one per cycle, while the
// output register is free, from a cached bitmap row; a row is fetched from the
// bitmap RAM at the first allocation after reset and again each time the
// cached row fills (16 blocks). When the bitmap runs out, a memory-full result
// follows the blocks taken.
// Read: each stored entry takes an index RAM read, then a load of the result.
// Reset: every block free and the file empty at once; each bitmap row carries a
// valid bit so no clearing pass runs.
// Stall: a result waits in the output register while out_ready is low and the
// request in progress halts until it is taken.
`default_nettype none

module indexed_block_allocator_top #(
  parameter int TOTAL_BLOCKS     = iba_pkg::DEF_TOTAL_BLOCKS,
  parameter int FILE_BLOCK_LIMIT = iba_pkg::DEF_FILE_BLOCK_LIMIT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_req_type,
  input  wire logic [iba_pkg::COUNT_W-1:0]  in_block_count,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [iba_pkg::STAT_W-1:0]   out_status,
  output logic                              out_has_block,
  output logic      [iba_pkg::POS_W-1:0]    out_entry_position,
  output logic      [iba_pkg::BLK_W-1:0]    out_block_number,
  output logic                              out_last
);

  import iba_pkg::*;

  localparam int ROWS      = (TOTAL_BLOCKS + MAP_W - 1) / MAP_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_BITS = TOTAL_BLOCKS - (ROWS - 1) * MAP_W;
  localparam logic [MAP_W-1:0] PAD_LAST = ~(MAP_W'((33'd1 << LAST_BITS) - 33'd1));
  localparam int CNT_W     = $clog2(FILE_BLOCK_LIMIT + 1);
  localparam int IX_AW     = (FILE_BLOCK_LIMIT > 1) ? $clog2(FILE_BLOCK_LIMIT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT_ONE,
    S_AL_STEP,
    S_AL_FETCH,
    S_RD_ISSUE,
    S_RD_EMIT
  } state_t;

  state_t             state_r;
  status_t            pend_status_r;
  logic [CNT_W-1:0]   stored_r;
  logic [CNT_W-1:0]   target_r;
  logic [CNT_W-1:0]   pos_r;
  logic [ROW_W-1:0]   hint_r;
  logic               full_r;
  logic               word_ok_r;
  logic [MAP_W-1:0]   word_r;
  logic [ROWS-1:0]    row_valid_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_has_block_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [BLK_W-1:0]   out_blk_r;
  logic               out_last_r;

  logic               slot_free;
  logic               out_load;
  logic               alloc_fire;
  logic               bm_re;
  logic [MAP_W-1:0]   bm_rdata;
  logic [MAP_W-1:0]   fetched_word;
  logic [PICK_W-1:0]  pick;
  logic [MAP_W-1:0]   new_word;
  logic [31:0]        blk_wide;
  logic [31:0]        pos_wide;
  logic [BLK_W-1:0]   ix_rdata;
  logic               ix_re;
  logic               alloc_last;
  logic               rd_last;

  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign bm_re      = (state_r == S_AL_STEP) && !full_r && !word_ok_r;
  assign alloc_fire = (state_r == S_AL_STEP) && !full_r && word_ok_r && slot_free;
  assign out_load   = slot_free && ((state_r == S_EMIT_ONE) || (state_r == S_RD_EMIT) ||
                                    ((state_r == S_AL_STEP) && (full_r || word_ok_r)));
  assign ix_re      = (state_r == S_RD_ISSUE);
  assign pick       = lowest_zero(word_r);
  assign new_word   = word_r | (MAP_W'(1) << pick);
  assign blk_wide   = 32'({hint_r, pick});
  assign pos_wide   = 32'(pos_r);
  assign alloc_last = (pos_r == target_r - CNT_W'(1));
  assign rd_last    = (pos_r == stored_r - CNT_W'(1));

  assign fetched_word = (row_valid_r[hint_r] ? bm_rdata : '0) |
                        ((hint_r == ROW_W'(ROWS - 1)) ? PAD_LAST : '0);

  iba_ram #(
    .WIDTH (MAP_W),
    .DEPTH (ROWS),
    .AW    (ROW_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (alloc_fire),
    .waddr (hint_r),
    .wdata (new_word),
    .re    (bm_re),
    .raddr (hint_r),
    .rdata (bm_rdata)
  );

  iba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (FILE_BLOCK_LIMIT),
    .AW    (IX_AW)
  ) u_index (
    .clk   (clk),
    .we    (alloc_fire),
    .waddr (pos_r[IX_AW-1:0]),
    .wdata (blk_wide[BLK_W-1:0]),
    .re    (ix_re),
    .raddr (pos_r[IX_AW-1:0]),
    .rdata (ix_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stored_r    <= '0;
      hint_r      <= '0;
      full_r      <= 1'b0;
      word_ok_r   <= 1'b0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pos_r <= '0;
            if (in_req_type == REQ_READ) begin
              if (stored_r == '0) begin
                pend_status_r <= ST_OK;
                state_r       <= S_EMIT_ONE;
              end else begin
                state_r <= S_RD_ISSUE;
              end
            end else if (in_block_count > COUNT_W'(FILE_BLOCK_LIMIT)) begin
              stored_r      <= '0;
              pend_status_r <= ST_LIMIT;
              state_r       <= S_EMIT_ONE;
            end else if (in_block_count == '0) begin
              stored_r      <= '0;
              pend_status_r <= ST_OK;
              state_r       <= S_EMIT_ONE;
            end else begin
              target_r <= in_block_count[CNT_W-1:0];
              state_r  <= S_AL_STEP;
            end
          end
        end
        S_EMIT_ONE: begin
          if (slot_free) begin
            out_status_r    <= pend_status_r;
            out_has_block_r <= 1'b0;
            out_pos_r       <= '0;
            out_blk_r       <= '0;
            out_last_r      <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        S_AL_STEP: begin
          if (full_r) begin
            if (slot_free) begin
              stored_r        <= pos_r;
              out_status_r    <= ST_FULL;
              out_has_block_r <= 1'b0;
              out_pos_r       <= '0;
              out_blk_r       <= '0;
              out_last_r      <= 1'b1;
              state_r         <= S_IDLE;
            end
          end else if (!word_ok_r) begin
            state_r <= S_AL_FETCH;
          end else if (slot_free) begin
            row_valid_r[hint_r] <= 1'b1;
            word_r              <= new_word;
            if (&new_word) begin
              word_ok_r <= 1'b0;
              if (hint_r == ROW_W'(ROWS - 1)) begin
                full_r <= 1'b1;
              end else begin
                hint_r <= hint_r + ROW_W'(1);
              end
            end
            out_status_r    <= ST_OK;
            out_has_block_r <= 1'b1;
            out_pos_r       <= pos_wide[POS_W-1:0];
            out_blk_r       <= blk_wide[BLK_W-1:0];
            out_last_r      <= alloc_last;
            pos_r           <= pos_r + CNT_W'(1);
            if (alloc_last) begin
              stored_r <= target_r;
              state_r  <= S_IDLE;
            end
          end
        end
        S_AL_FETCH: begin
          word_r    <= fetched_word;
          word_ok_r <= 1'b1;
          state_r   <= S_AL_STEP;
        end
        S_RD_ISSUE: begin
          state_r <= S_RD_EMIT;
        end
        S_RD_EMIT: begin
          if (slot_free) begin
            out_status_r    <= ST_OK;
            out_has_block_r <= 1'b1;
            out_pos_r       <= pos_wide[POS_W-1:0];
            out_blk_r       <= ix_rdata;
            out_last_r      <= rd_last;
            pos_r           <= pos_r + CNT_W'(1);
            state_r         <= rd_last ? S_IDLE : S_RD_ISSUE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_has_block      = out_has_block_r;
  assign out_entry_position = out_pos_r;
  assign out_block_number   = out_blk_r;
  assign out_last           = out_last_r;

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("bitmap full flag dropped");

  a_cached_row_open: assert property (@(posedge clk) disable iff (!rst_n)
    (word_ok_r && !full_r) |-> !(&word_r))
    else $error("cached bitmap row has no free block");

  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CNT_W'(FILE_BLOCK_LIMIT))
    else $error("stored count beyond file limit");

  a_block_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_block_r) |-> (out_status_r == ST_OK))
    else $error("result with block carries error status");

  a_idle_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AL_FETCH) |-> ($past(bm_re) && !full_r))
    else $error("bitmap fetch state without a read");

endmodule

`default_nettype wire
